// ===== rtl/core/nsp_pkg.sv =====
// Shared types, character codes and helpers for the NMEA sentence parser.
// No dependencies; used by nsp_step, nsp_out_buf and nmea_sentence_parser in rtl/core.
`timescale 1ns / 1ps

package nsp_pkg;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FIELDS = 5'b00010,
    PH_DIG1   = 5'b00100,
    PH_DIG2   = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  // result event codes
  localparam logic [1:0] EV_STRAY = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_FEND  = 2'd2;
  localparam logic [1:0] EV_SEND  = 2'd3;

  // checksum status codes at sentence end
  localparam logic [1:0] CK_NONE = 2'd0;
  localparam logic [1:0] CK_OK   = 2'd1;
  localparam logic [1:0] CK_ERR  = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A_M10  = 8'h37;  // 'A' minus ten
  localparam logic [7:0] FC_MAX    = 8'hFF;

  // number of results one beat may cause, 0 to 2
  localparam int unsigned MAX_RES = 2;
  typedef logic [1:0] res_cnt_t;

  // one result beat
  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] field_number;
    logic [1:0] check_status;
    logic       last;
  } res_t;

  // results produced by the parser for one input beat
  typedef struct packed {
    res_cnt_t n_res;
    res_t     r0;
    res_t     r1;
  } res_pair_t;

  // uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_char = wide + CH_ZERO;
    end else begin
      hex_char = wide + CH_A_M10;
    end
  endfunction

endpackage

// ===== rtl/core/nsp_if.sv =====
// Valid/ready channel interfaces for the parser input and result streams.
// Standalone; the result payload matches the field widths of nsp_pkg::res_t.
`timescale 1ns / 1ps

interface nsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] field_number;
  logic [1:0] check_status;
  logic       last;

  modport source (output valid, output event_res, output data_byte, output field_number,
                  output check_status, output last, input ready);
  modport sink (input valid, input event_res, input data_byte, input field_number,
                input check_status, input last, output ready);
endinterface

// ===== rtl/core/nsp_step.sv =====
// Parser state (phase, running checksum, field counter) and per-byte decode.
// Depends on nsp_pkg.
`timescale 1ns / 1ps

module nsp_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         rx_byte,
  output nsp_pkg::res_pair_t res
);

  nsp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      xor_r, xor_nxt;
  logic [7:0]      fc_r, fc_nxt;
  logic            eol;

  assign eol = (rx_byte == nsp_pkg::CH_CR) || (rx_byte == nsp_pkg::CH_LF);

  // decode one byte against the current phase
  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    fc_nxt    = fc_r;
    res       = '0;
    case (phase_r)
      nsp_pkg::PH_FIELDS: begin
        if (rx_byte == nsp_pkg::CH_COMMA) begin
          res.n_res = 2'd1;
          res.r0    = '{nsp_pkg::EV_FEND, 8'd0, fc_r, nsp_pkg::CK_NONE, 1'b1};
          xor_nxt   = xor_r ^ rx_byte;
          if (fc_r != nsp_pkg::FC_MAX) begin
            fc_nxt = fc_r + 8'd1;
          end
        end else if (rx_byte == nsp_pkg::CH_STAR) begin
          res.n_res = 2'd1;
          res.r0    = '{nsp_pkg::EV_FEND, 8'd0, fc_r, nsp_pkg::CK_NONE, 1'b1};
          phase_nxt = nsp_pkg::PH_DIG1;
        end else if (eol) begin
          // field end then sentence end, no checksum
          res.n_res = 2'd2;
          res.r0    = '{nsp_pkg::EV_FEND, 8'd0, fc_r, nsp_pkg::CK_NONE, 1'b0};
          res.r1    = '{nsp_pkg::EV_SEND, 8'd0, fc_r, nsp_pkg::CK_NONE, 1'b1};
          phase_nxt = nsp_pkg::PH_IDLE;
        end else begin
          res.n_res = 2'd1;
          res.r0    = '{nsp_pkg::EV_BYTE, rx_byte, fc_r, nsp_pkg::CK_NONE, 1'b1};
          xor_nxt   = xor_r ^ rx_byte;
        end
      end
      nsp_pkg::PH_DIG1: begin
        if (!eol && (rx_byte == nsp_pkg::hex_char(xor_r[7:4]))) begin
          phase_nxt = nsp_pkg::PH_DIG2;
        end else begin
          res.n_res = 2'd1;
          res.r0    = '{nsp_pkg::EV_SEND, 8'd0, fc_r, nsp_pkg::CK_ERR, 1'b1};
          phase_nxt = eol ? nsp_pkg::PH_IDLE : nsp_pkg::PH_SKIP;
        end
      end
      nsp_pkg::PH_DIG2: begin
        res.n_res = 2'd1;
        res.r0    = '{nsp_pkg::EV_SEND, 8'd0, fc_r,
                      (rx_byte == nsp_pkg::hex_char(xor_r[3:0])) ?
                        nsp_pkg::CK_OK : nsp_pkg::CK_ERR,
                      1'b1};
        phase_nxt = nsp_pkg::PH_IDLE;
      end
      nsp_pkg::PH_SKIP: begin
        phase_nxt = nsp_pkg::PH_IDLE;
      end
      default: begin
        // idle: wait for a dollar, report anything else as stray
        if (rx_byte == nsp_pkg::CH_DOLLAR) begin
          phase_nxt = nsp_pkg::PH_FIELDS;
          xor_nxt   = 8'd0;
          fc_nxt    = 8'd0;
        end else begin
          phase_nxt = nsp_pkg::PH_IDLE;
          res.n_res = 2'd1;
          res.r0    = '{nsp_pkg::EV_STRAY, rx_byte, 8'd0, nsp_pkg::CK_NONE, 1'b1};
        end
      end
    endcase
  end

  // state update on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nsp_pkg::PH_IDLE;
      xor_r   <= 8'd0;
      fc_r    <= 8'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      fc_r    <= fc_nxt;
    end
  end

endmodule

// ===== rtl/core/nsp_out_buf.sv =====
// Two-entry result queue between the parser decode and the result channel.
// Depends on nsp_pkg.
`timescale 1ns / 1ps

module nsp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  nsp_pkg::res_cnt_t  push_n,
  input  nsp_pkg::res_t      push_r0,
  input  nsp_pkg::res_t      push_r1,
  input  logic               out_ready,
  output logic               out_valid,
  output nsp_pkg::res_t      out_res,
  output logic               space_ok
);

  nsp_pkg::res_t      e0_r, e0_nxt;
  nsp_pkg::res_t      e1_r, e1_nxt;
  nsp_pkg::res_cnt_t  count_r, count_nxt;
  nsp_pkg::res_cnt_t  kept;
  logic               pop;

  assign out_valid = (count_r != 2'd0);
  assign out_res   = e0_r;
  assign pop       = out_valid && out_ready;

  // room for the largest burst one input beat can cause
  assign space_ok = (count_r == 2'd0) || ((count_r == 2'd1) && out_ready);

  // shift out the head, then append new results behind what is kept
  always_comb begin
    e0_nxt = e0_r;
    e1_nxt = e1_r;
    if (pop) begin
      e0_nxt = e1_r;
    end
    kept = count_r - {1'b0, pop};
    if (push_n != 2'd0) begin
      if (kept == 2'd0) begin
        e0_nxt = push_r0;
      end else begin
        e1_nxt = push_r0;
      end
    end
    if (push_n == 2'd2) begin
      e1_nxt = push_r1;
    end
    count_nxt = kept + push_n;
  end

  // entry payloads
  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  // fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue fill level out of range");

  a_burst_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> ((count_r == 2'd0) || ((count_r == 2'd1) && pop)))
    else $error("two-result burst pushed without room");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |=> (count_r != 2'd0))
    else $error("pushed result lost");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (count_r == 2'd2)) |=> (e0_r == $past(e1_r)))
    else $error("result queue order broken");
`endif

endmodule

// ===== rtl/core/nmea_sentence_parser.sv =====
// NMEA sentence parser: one received byte per beat in, field and sentence events out.
// Results are registered in the result queue before they are offered on the output.
// Throughput: one byte per cycle while results are taken; a CR/LF inside fields gives
// two results, fills the two-entry result queue and holds the input while the queue is full.
// Synchronous active-low reset: parser idle, checksum and field counter cleared, queue empty.
// Depends on nsp_pkg, nsp_if, nsp_step and nsp_out_buf.
`timescale 1ns / 1ps

module nmea_sentence_parser (
  input  logic       clk,
  input  logic       rst_n,
  nsp_in_if.sink     in_ch,
  nsp_out_if.source  out_ch
);

  nsp_pkg::res_pair_t res;
  nsp_pkg::res_cnt_t  push_n;
  nsp_pkg::res_t      head;
  logic               in_fire;
  logic               space_ok;

  assign in_ch.ready = space_ok;
  assign in_fire     = in_ch.valid && space_ok;
  assign push_n      = in_fire ? res.n_res : 2'd0;

  // per-byte parse and state
  nsp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_ch.rx_byte),
    .res     (res)
  );

  // result queue toward the output channel
  nsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_r0   (res.r0),
    .push_r1   (res.r1),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (head),
    .space_ok  (space_ok)
  );

  // output beat payload
  assign out_ch.event_res    = head.event_res;
  assign out_ch.data_byte    = head.data_byte;
  assign out_ch.field_number = head.field_number;
  assign out_ch.check_status = head.check_status;
  assign out_ch.last         = head.last;

endmodule

// ===== tb/sv/nmea_sentence_parser_tb.sv =====
// Self-checking testbench for nmea_sentence_parser: byte stream in, parse events out.
// Depends on nsp_pkg, the nsp_in_if / nsp_out_if channel interfaces and the parser RTL.
`timescale 1ns / 1ps

module nmea_sentence_parser_tb;

  // shape of the end of a generated sentence
  typedef enum int {
    TL_GOOD, TL_BAD_HI, TL_BAD_LO, TL_LOWER, TL_EOL, TL_EOL_DIG, TL_CUT
  } tail_t;

  // receiver back-pressure patterns
  typedef enum int {RX_FREE, RX_COIN, RX_THIRD, RX_LONG} rx_mode_t;

  localparam int RANDOM_BYTES = 1600;

  logic clk;
  logic rst_n;

  nsp_in_if  in_if ();
  nsp_out_if out_if ();

  nmea_sentence_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // stimulus and expected events
  logic [7:0]    stim_q [$];
  nsp_pkg::res_t pending_events [$];

  // parser state as the scoreboard sees it
  nsp_pkg::phase_t sim_phase;
  logic [7:0]      sum_xor;
  logic [7:0]      field_idx;

  // handshake bookkeeping
  bit       in_taken;
  bit       hold_send;
  int       n_made;
  int       n_directed;
  int       bytes_taken;
  int       gap_left;
  int       burst_left;
  int       err_cnt;

  // coverage counters for the summary
  int       events_seen;
  int       sums_ok;
  int       sums_bad;
  int       unchecked_ends;
  int       stray_seen;
  int       top_field;

  // receiver pattern state
  rx_mode_t rx_mode;
  int       mode_left;
  int       stall_left;
  int       third_ctr;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] hex_of(input logic [3:0] nib);
    string digits;
    digits = "0123456789ABCDEF";
    return digits[nib];
  endfunction

  function automatic logic [7:0] lower_hex(input logic [7:0] c);
    return (c >= 8'h41) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == nsp_pkg::CH_STAR || c == nsp_pkg::CH_COMMA) c = 8'h5F;
    end
    return c;
  endfunction

  task automatic put(input logic [7:0] b);
    stim_q.push_back(b);
    n_made++;
  endtask

  // payload byte that also goes into the running checksum
  task automatic body(input logic [7:0] b, inout logic [7:0] ck);
    put(b);
    ck ^= b;
  endtask

  task automatic add_tail(input logic [7:0] ck, input tail_t tail);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [3:0] flip;
    logic [7:0] junk;
    hi = hex_of(ck[7:4]);
    lo = hex_of(ck[3:0]);
    flip = 4'($urandom_range(1, 15));
    junk = 8'($urandom_range(0, 255));
    case (tail)
      TL_GOOD: begin
        put(nsp_pkg::CH_STAR); put(hi); put(lo); put(nsp_pkg::CH_CR); put(nsp_pkg::CH_LF);
      end
      TL_BAD_HI: begin
        // wrong first digit, then a byte that gets swallowed
        put(nsp_pkg::CH_STAR); put(hex_of(ck[7:4] ^ flip)); put(junk);
      end
      TL_BAD_LO: begin
        put(nsp_pkg::CH_STAR); put(hi);
        put($urandom_range(0, 1) ? hex_of(ck[3:0] ^ flip) : junk);
      end
      TL_LOWER: begin
        put(nsp_pkg::CH_STAR); put(lower_hex(hi)); put(lower_hex(lo));
      end
      TL_EOL: begin
        put($urandom_range(0, 1) ? nsp_pkg::CH_CR : nsp_pkg::CH_LF);
      end
      TL_EOL_DIG: begin
        put(nsp_pkg::CH_STAR); put($urandom_range(0, 1) ? nsp_pkg::CH_CR : nsp_pkg::CH_LF);
      end
      default: begin
        // sentence left open; whatever follows lands in its fields
      end
    endcase
  endtask

  task automatic add_sentence(input int n_fields, input int max_len, input tail_t tail);
    logic [7:0] ck;
    int         len;
    ck = 8'h00;
    put(nsp_pkg::CH_DOLLAR);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) body(nsp_pkg::CH_COMMA, ck);
      len = $urandom_range(0, max_len);
      for (int j = 0; j < len; j++) body(payload_char(), ck);
    end
    add_tail(ck, tail);
  endtask

  task automatic expect_event(input logic [1:0] ev, input logic [7:0] data,
                              input logic [7:0] fnum, input logic [1:0] status,
                              input logic lst);
    nsp_pkg::res_t r;
    r.event_res    = ev;
    r.data_byte    = data;
    r.field_number = fnum;
    r.check_status = status;
    r.last         = lst;
    pending_events.push_back(r);
  endtask

  // advance the parser state by one accepted byte and queue its events
  task automatic follow_byte(input logic [7:0] b);
    logic eol;
    eol = (b == nsp_pkg::CH_CR) || (b == nsp_pkg::CH_LF);
    case (sim_phase)
      nsp_pkg::PH_FIELDS: begin
        if (b == nsp_pkg::CH_COMMA) begin
          expect_event(nsp_pkg::EV_FEND, 8'h00, field_idx, nsp_pkg::CK_NONE, 1'b1);
          sum_xor ^= b;
          if (field_idx != nsp_pkg::FC_MAX) field_idx = field_idx + 8'd1;
        end else if (b == nsp_pkg::CH_STAR) begin
          expect_event(nsp_pkg::EV_FEND, 8'h00, field_idx, nsp_pkg::CK_NONE, 1'b1);
          sim_phase = nsp_pkg::PH_DIG1;
        end else if (eol) begin
          expect_event(nsp_pkg::EV_FEND, 8'h00, field_idx, nsp_pkg::CK_NONE, 1'b0);
          expect_event(nsp_pkg::EV_SEND, 8'h00, field_idx, nsp_pkg::CK_NONE, 1'b1);
          sim_phase = nsp_pkg::PH_IDLE;
        end else begin
          sum_xor ^= b;
          expect_event(nsp_pkg::EV_BYTE, b, field_idx, nsp_pkg::CK_NONE, 1'b1);
        end
      end
      nsp_pkg::PH_DIG1: begin
        if (!eol && b == hex_of(sum_xor[7:4])) begin
          sim_phase = nsp_pkg::PH_DIG2;
        end else begin
          expect_event(nsp_pkg::EV_SEND, 8'h00, field_idx, nsp_pkg::CK_ERR, 1'b1);
          sim_phase = eol ? nsp_pkg::PH_IDLE : nsp_pkg::PH_SKIP;
        end
      end
      nsp_pkg::PH_DIG2: begin
        expect_event(nsp_pkg::EV_SEND, 8'h00, field_idx,
                     (b == hex_of(sum_xor[3:0])) ? nsp_pkg::CK_OK : nsp_pkg::CK_ERR, 1'b1);
        sim_phase = nsp_pkg::PH_IDLE;
      end
      nsp_pkg::PH_SKIP: begin
        sim_phase = nsp_pkg::PH_IDLE;
      end
      default: begin
        if (b == nsp_pkg::CH_DOLLAR) begin
          sim_phase = nsp_pkg::PH_FIELDS;
          sum_xor   = 8'h00;
          field_idx = 8'h00;
        end else begin
          sim_phase = nsp_pkg::PH_IDLE;
          expect_event(nsp_pkg::EV_STRAY, b, 8'h00, nsp_pkg::CK_NONE, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_event(input nsp_pkg::res_t got);
    nsp_pkg::res_t want;
    if (pending_events.size() == 0) begin
      $error("unexpected result: event_res %0d data_byte %0h field_number %0d",
             got.event_res, got.data_byte, got.field_number);
      err_cnt++;
    end else begin
      want = pending_events.pop_front();
      if (got.event_res !== want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
        err_cnt++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        err_cnt++;
      end
      if (got.field_number !== want.field_number) begin
        $error("field_number: expected %0d, got %0d", want.field_number, got.field_number);
        err_cnt++;
      end
      if (got.check_status !== want.check_status) begin
        $error("check_status: expected %0d, got %0d", want.check_status, got.check_status);
        err_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        err_cnt++;
      end
    end
  endtask

  // input beat accepted, result beat checked
  always @(posedge clk) begin
    nsp_pkg::res_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        follow_byte(in_if.rx_byte);
        bytes_taken++;
        in_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.event_res    = out_if.event_res;
        got.data_byte    = out_if.data_byte;
        got.field_number = out_if.field_number;
        got.check_status = out_if.check_status;
        got.last         = out_if.last;
        check_event(got);
        events_seen++;
        if (got.event_res == nsp_pkg::EV_STRAY) stray_seen++;
        if (got.event_res == nsp_pkg::EV_SEND) begin
          if (got.check_status == nsp_pkg::CK_OK) sums_ok++;
          else if (got.check_status == nsp_pkg::CK_ERR) sums_bad++;
          else unchecked_ends++;
        end
        if (int'(got.field_number) > top_field) top_field = int'(got.field_number);
      end
    end
  end

  // sender: bursts of beats with random gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (hold_send || stim_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= stim_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 1) ? $urandom_range(20, 60) : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: ready follows a pattern that switches every so often
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 200);
    end else begin
      mode_left--;
    end
    third_ctr = (third_ctr == 2) ? 0 : third_ctr + 1;
    case (rx_mode)
      RX_FREE:  out_if.ready <= 1'b1;
      RX_COIN:  out_if.ready <= 1'($urandom_range(0, 1));
      RX_THIRD: out_if.ready <= (third_ctr != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // run limit
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] ck;
    int         roll;
    int         pause_mark [2];
    bit         sat_done;
    tail_t      tl;

    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    sim_phase     = nsp_pkg::PH_IDLE;
    sum_xor       = 8'h00;
    field_idx     = 8'h00;
    in_taken      = 1'b0;
    hold_send     = 1'b0;
    rx_mode       = RX_FREE;
    sat_done      = 1'b0;

    // directed: stray extremes, dollar inside a sentence, each checksum outcome
    put(8'h00);
    put(8'hFF);
    ck = 8'h00;
    put(nsp_pkg::CH_DOLLAR); body(8'h47, ck); body(nsp_pkg::CH_COMMA, ck);
    body(8'h80, ck); body(nsp_pkg::CH_DOLLAR, ck);
    add_tail(ck, TL_GOOD);
    ck = 8'h00;
    put(nsp_pkg::CH_DOLLAR); body(8'h41, ck);
    add_tail(ck, TL_BAD_HI);
    put(nsp_pkg::CH_DOLLAR);
    add_tail(8'h00, TL_EOL_DIG);
    put(nsp_pkg::CH_DOLLAR); put(8'h42); put(nsp_pkg::CH_LF);
    ck = 8'h00;
    put(nsp_pkg::CH_DOLLAR); body(8'hAB, ck);
    add_tail(ck, TL_LOWER);
    n_directed = n_made;

    // random: sentences with assorted endings, some noise, one long enough to saturate
    while (n_made < n_directed + RANDOM_BYTES) begin
      roll = $urandom_range(0, 99);
      if (!sat_done && n_made > n_directed + 600) begin
        add_sentence(300, 1, TL_GOOD);
        sat_done = 1'b1;
      end else if (roll < 12) begin
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) tl = TL_GOOD;
        else if (roll < 50) tl = TL_BAD_HI;
        else if (roll < 60) tl = TL_BAD_LO;
        else if (roll < 68) tl = TL_LOWER;
        else if (roll < 83) tl = TL_EOL;
        else if (roll < 91) tl = TL_EOL_DIG;
        else tl = TL_CUT;
        add_sentence($urandom_range(1, 8), $urandom_range(0, 6), tl);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain completely once after the directed part and once midway
    pause_mark[0] = n_directed;
    pause_mark[1] = n_directed + RANDOM_BYTES / 2;
    foreach (pause_mark[k]) begin
      while (bytes_taken < pause_mark[k]) @(posedge clk);
      hold_send = 1'b1;
      while (in_if.valid || pending_events.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      hold_send = 1'b0;
    end

    while (stim_q.size() != 0 || in_if.valid || pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes giving %0d events: %0d stray, %0d good sums, %0d bad sums,",
             bytes_taken, events_seen, stray_seen, sums_ok, sums_bad);
    $display("%0d sentences ended without a sum; highest field index %0d",
             unchecked_ends, top_field);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
